FILE: sv/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
// No dependencies; imported by sdf_ctrl, sdf_datapath and stream_duplicate_filter_top.
package sdf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef struct packed {
    value_t value;
    logic   is_last;
  } in_item_t;

  typedef struct packed {
    value_t out_value;
    logic   keep;
    logic   out_last;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } sdf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rd_pending;
    logic out_busy;
  } sdf_status_t;

endpackage

FILE: sv/sdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sdf_ctrl.sv
// Controller state machine for the stream duplicate filter.
// Depends on sdf_pkg; drives commands into sdf_datapath.
module sdf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sdf_pkg::sdf_status_t status,
  output sdf_pkg::sdf_cmd_t    cmd
);
  import sdf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status.scan_done) begin
          cmd.issue = 1'b1;
        end else if (!status.rd_pending) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/sdf_datapath.sv
// Datapath: held item, seen-value table, scan counter and result register.
// Depends on sdf_pkg and sdf_ram; commanded by sdf_ctrl.
module sdf_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sdf_pkg::in_item_t    item,
  input  sdf_pkg::sdf_cmd_t    cmd,
  output sdf_pkg::sdf_status_t status,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sdf_pkg::out_item_t   result
);
  import sdf_pkg::*;

  in_item_t cur;
  count_t   seen_count;
  count_t   idx;
  logic     found;
  logic     rd_pending;
  value_t   rdata;
  logic     full;
  logic     store;
  count_t   seen_count_next;

  sdf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (store),
    .waddr (seen_count[ADDR_W-1:0]),
    .wdata (cur.value),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign full  = (seen_count == count_t'(TABLE_DEPTH));
  assign store = cmd.finish && !found && !full;

  always_comb begin
    if (cur.is_last) begin
      seen_count_next = '0;
    end else if (store) begin
      seen_count_next = seen_count + count_t'(1);
    end else begin
      seen_count_next = seen_count;
    end
  end

  assign status.scan_done  = found || (idx == seen_count);
  assign status.rd_pending = rd_pending;
  assign status.out_busy   = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.finish) begin
      result.out_value <= cur.value;
      result.keep      <= !found;
      result.out_last  <= cur.is_last;
      result.overflow  <= !found && full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count   <= '0;
      idx          <= '0;
      found        <= 1'b0;
      rd_pending   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_pending <= cmd.issue;
      if (cmd.load) begin
        idx   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx <= idx + count_t'(1);
        end
        if (rd_pending && (rdata == cur.value)) begin
          found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        seen_count   <= seen_count_next;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/stream_duplicate_filter_top.sv
// Stream duplicate filter: passes each list value with a first-occurrence keep flag.
// Top level; depends on sdf_pkg, sdf_ctrl and sdf_datapath.
//
// Each accepted value is compared against the distinct values already seen in the
// current list, one table entry per cycle through the single read port of the table
// RAM. The scan ends early when a match is found, and it covers at most TABLE_DEPTH
// entries once the table is full. A stalled output holds the item in the finish state
// until the result register is free.
// A new item is taken while the previous result still waits in the output register.
// Values not found are stored while room remains; once the table is full they are
// kept and flagged overflow. The table empties after an is_last item.
module stream_duplicate_filter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  sdf_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output sdf_pkg::out_item_t result
);
  import sdf_pkg::*;

  sdf_cmd_t    cmd;
  sdf_status_t status;

  sdf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  sdf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
